// ===== design/med2l_pkg.sv =====
// Shared constants and types for the median of two sorted lists unit
package med2l_pkg;

  // list storage geometry
  localparam int unsigned LIST_DEPTH = 1024;
  localparam int unsigned IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned TOT_W      = CNT_W + 1;

  // word widths
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned MED_W      = VAL_W + 1;
  localparam int unsigned OUT_DATA_W = ((MED_W + 7) / 8) * 8;
  localparam int unsigned OP_W       = 2;

  // input word opcodes carried on tuser
  typedef enum logic [OP_W-1:0] {
    OP_APPEND_FIRST  = 2'd0,
    OP_APPEND_SECOND = 2'd1,
    OP_COMPUTE       = 2'd2
  } opcode_e;

  // result flags carried on tuser, highest bit first
  typedef struct packed {
    logic dropped;
    logic set_empty;
  } res_flags_t;

endpackage

// ===== design/med2l_ram.sv =====
// Simple dual-port list memory with one write port and a registered read port
module med2l_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/median_of_two_sorted_lists_unit.sv =====
// Top level: two list memories, append path and merge walk for twice the median
//
//  channel | dir | tdata                          | tuser
//  s_axis  | in  | [31:0] value                   | [1:0] opcode
//  m_axis  | out | [32:0] median_doubled, 0 pad   | [0] set_empty, [1] dropped
//
// Appends and unused opcodes are taken one word per cycle.
// A compute word on a non-empty set walks the merged lists one element per
// cycle, reading both memories every cycle, up to the middle element; the
// result loads once the output register is free. Input is not taken until
// then; appends keep flowing while a loaded result waits to be taken.
// Reset clears counts, drop flag and control; list contents are not cleared.
module median_of_two_sorted_lists_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [32:0] median_doubled, [39:33] zero
  output logic [1:0]  m_axis_tuser_o    // [0] set_empty, [1] dropped
);

  localparam int unsigned IDX_W = med2l_pkg::IDX_W;
  localparam int unsigned CNT_W = med2l_pkg::CNT_W;
  localparam int unsigned TOT_W = med2l_pkg::TOT_W;
  localparam int unsigned VAL_W = med2l_pkg::VAL_W;
  localparam int unsigned MED_W = med2l_pkg::MED_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      fc_q, fc_d;
  logic [CNT_W-1:0]      sc_q, sc_d;
  logic                  ovf_q, ovf_d;
  logic [CNT_W-1:0]      i_q, i_d;
  logic [CNT_W-1:0]      j_q, j_d;
  logic [CNT_W-1:0]      k_q, k_d;
  logic [CNT_W-1:0]      half_q, half_d;
  logic                  odd_q, odd_d;
  logic signed [VAL_W-1:0] curr_q, curr_d;
  logic signed [MED_W-1:0] res_q, res_d;
  logic                  res_empty_q, res_empty_d;
  logic                  res_drop_q, res_drop_d;
  logic                  out_valid_q, out_valid_d;
  logic [MED_W-1:0]      out_med_q;
  med2l_pkg::res_flags_t out_flags_q;

  logic                  in_acc;
  logic                  out_free;
  med2l_pkg::opcode_e    opcode;
  logic [TOT_W-1:0]      total;
  logic                  we_a, we_b;
  logic signed [VAL_W-1:0] a_rd, b_rd;
  logic                  take_first;
  logic signed [VAL_W-1:0] taken;
  logic signed [MED_W-1:0] med_val;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign opcode          = med2l_pkg::opcode_e'(s_axis_tuser_i);
  assign total           = {1'b0, fc_q} + {1'b0, sc_q};

  // append writes, only while the target list has room
  assign we_a = in_acc && (opcode == med2l_pkg::OP_APPEND_FIRST)
                && (fc_q < CNT_W'(med2l_pkg::LIST_DEPTH));
  assign we_b = in_acc && (opcode == med2l_pkg::OP_APPEND_SECOND)
                && (sc_q < CNT_W'(med2l_pkg::LIST_DEPTH));

  // list memories, read address follows the next walk index
  med2l_ram #(
    .DEPTH (med2l_pkg::LIST_DEPTH),
    .WIDTH (VAL_W)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (fc_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (i_d[IDX_W-1:0]),
    .rdata_o (a_rd)
  );

  med2l_ram #(
    .DEPTH (med2l_pkg::LIST_DEPTH),
    .WIDTH (VAL_W)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (sc_q[IDX_W-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (j_d[IDX_W-1:0]),
    .rdata_o (b_rd)
  );

  // merge choice: second head wins only when strictly smaller
  always_comb begin
    priority if (i_q >= fc_q) begin
      take_first = 1'b0;
    end else if (j_q >= sc_q) begin
      take_first = 1'b1;
    end else begin
      take_first = !(a_rd > b_rd);
    end
  end

  assign taken = take_first ? a_rd : b_rd;

  // odd total doubles the middle, even total adds the two middles
  assign med_val = odd_q ? {taken, 1'b0}
                         : (MED_W'(taken) + MED_W'(curr_q));

  // next state and control
  always_comb begin
    state_d     = state_q;
    fc_d        = fc_q;
    sc_d        = sc_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    half_d      = half_q;
    odd_d       = odd_q;
    curr_d      = curr_q;
    res_d       = res_q;
    res_empty_d = res_empty_q;
    res_drop_d  = res_drop_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode)
            med2l_pkg::OP_APPEND_FIRST: begin
              if (we_a) begin
                fc_d = fc_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            med2l_pkg::OP_APPEND_SECOND: begin
              if (we_b) begin
                sc_d = sc_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            med2l_pkg::OP_COMPUTE: begin
              i_d         = '0;
              j_d         = '0;
              k_d         = '0;
              half_d      = total[TOT_W-1:1];
              odd_d       = total[0];
              curr_d      = '0;
              res_d       = '0;
              res_drop_d  = ovf_q;
              res_empty_d = (total == '0);
              if (total == '0) begin
                fc_d    = '0;
                sc_d    = '0;
                ovf_d   = 1'b0;
                state_d = ST_DRAIN;
              end else begin
                state_d = ST_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // one merged element per cycle
        if (take_first) begin
          i_d = i_q + CNT_W'(1);
        end else begin
          j_d = j_q + CNT_W'(1);
        end
        curr_d = taken;
        k_d    = k_q + CNT_W'(1);
        if (k_q == half_q) begin
          res_d   = med_val;
          fc_d    = '0;
          sc_d    = '0;
          ovf_d   = 1'b0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fc_q        <= '0;
      sc_q        <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      sc_q        <= sc_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk_i) begin
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    half_q      <= half_d;
    odd_q       <= odd_d;
    curr_q      <= curr_d;
    res_q       <= res_d;
    res_empty_q <= res_empty_d;
    res_drop_q  <= res_drop_d;
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DRAIN) && out_free) begin
      out_med_q             <= res_q;
      out_flags_q.set_empty <= res_empty_q;
      out_flags_q.dropped   <= res_drop_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(med2l_pkg::OUT_DATA_W - MED_W){1'b0}}, out_med_q};
  assign m_axis_tuser_o  = {out_flags_q.dropped, out_flags_q.set_empty};

`ifndef SYNTHESIS
  // walk indexes stay within the stored counts
  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((i_q <= fc_q) && (j_q <= sc_q)))
    else $error("walk index past list count");

  // some list still has an element while walking
  a_walk_avail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((i_q < fc_q) || (j_q < sc_q)))
    else $error("walk with both lists exhausted");

  // step counter never passes the middle
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (k_q <= half_q))
    else $error("walk step past middle");

  // lists and drop flag are cleared once a result is pending
  a_drain_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> ((fc_q == '0) && (sc_q == '0) && !ovf_q))
    else $error("lists not cleared after compute");
`endif

endmodule

// ===== sim/median_of_two_sorted_lists_unit_tb.sv =====
// Self-checking testbench for the median of two sorted lists unit
`timescale 1ns / 100ps

module median_of_two_sorted_lists_unit_tb;

  localparam int unsigned LIST_DEPTH = med2l_pkg::LIST_DEPTH;
  localparam int unsigned VAL_W      = med2l_pkg::VAL_W;
  localparam int unsigned MED_W      = med2l_pkg::MED_W;
  localparam int unsigned OP_W       = med2l_pkg::OP_W;

  // opcode with no effect on the block
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN_W = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX_W = 32'h7fff_ffff;
  localparam longint VAL_MAX = 64'sd2147483647;

  // receiver ready patterns
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_CYCLIC  = 2;
  localparam int RX_SPARSE  = 3;

  typedef struct {
    logic signed [MED_W-1:0] median;
    logic                    set_empty;
    logic                    dropped;
  } median_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;
  logic [1:0]  s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [39:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  // predictor state: both lists, their fill counts and the drop flag
  logic signed [VAL_W-1:0] first_mem  [LIST_DEPTH];
  logic signed [VAL_W-1:0] second_mem [LIST_DEPTH];
  int unsigned             first_cnt;
  int unsigned             second_cnt;
  logic                    append_dropped;

  median_result_t        median_expect_q[$];
  median_result_t        exp_res;
  med2l_pkg::res_flags_t got_flags;

  // word runs staged for the next set
  logic signed [VAL_W-1:0] first_run[$];
  logic signed [VAL_W-1:0] second_run[$];

  int error_count;
  int results_checked;
  int words_sent;
  int burst_left;
  bit gaps_on;
  int rx_mode;
  int rx_phase;
  int hold_left;

  median_of_two_sorted_lists_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // [31:0] value
    .s_axis_tuser_i  (s_axis_tuser_i),   // [1:0] opcode
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [32:0] median_doubled, [39:33] zero
    .m_axis_tuser_o  (m_axis_tuser_o)    // [0] set_empty, [1] dropped
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("median_of_two_sorted_lists_unit regression: fail");
    $finish;
  end

  // track one accepted word: update the lists and queue the median on compute
  task automatic predict_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
    int unsigned             total;
    int unsigned             half;
    int unsigned             i;
    int unsigned             j;
    int unsigned             k;
    logic signed [MED_W-1:0] prev;
    logic signed [MED_W-1:0] curr;
    bit                      take_first;
    median_result_t          res;
    case (op)
      med2l_pkg::OP_APPEND_FIRST: begin
        if (first_cnt < LIST_DEPTH) begin
          first_mem[first_cnt] = val;
          first_cnt++;
        end else begin
          append_dropped = 1'b1;
        end
      end
      med2l_pkg::OP_APPEND_SECOND: begin
        if (second_cnt < LIST_DEPTH) begin
          second_mem[second_cnt] = val;
          second_cnt++;
        end else begin
          append_dropped = 1'b1;
        end
      end
      med2l_pkg::OP_COMPUTE: begin
        total = first_cnt + second_cnt;
        prev  = '0;
        curr  = '0;
        i     = 0;
        j     = 0;
        // merge walk up to the middle, second head wins only when strictly smaller
        if (total != 0) begin
          half = total / 2;
          for (k = 0; k <= half; k++) begin
            if (i >= first_cnt) take_first = 1'b0;
            else if (j >= second_cnt) take_first = 1'b1;
            else take_first = !(first_mem[i] > second_mem[j]);
            prev = curr;
            if (take_first) begin
              curr = first_mem[i];
              i++;
            end else begin
              curr = second_mem[j];
              j++;
            end
          end
        end
        res.median    = (total % 2 == 1) ? curr + curr : curr + prev;
        res.set_empty = (total == 0);
        res.dropped   = append_dropped;
        median_expect_q.insert(median_expect_q.size(), res);
        first_cnt      = 0;
        second_cnt     = 0;
        append_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  // offer one word, in bursts with random gaps if enabled, wait for the handshake
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (gaps_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= val;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_word(op, val);
    words_sent++;
    burst_left--;
  endtask

  // stage two runs: non-decreasing with a chosen spread, or raw random values
  task automatic build_runs(input int n_first, input int n_second, input bit ordered);
    logic signed [VAL_W-1:0] r;
    longint                  cur;
    int                      spread;
    int                      side;
    int                      n;
    int                      k;
    first_run.delete();
    second_run.delete();
    spread = $urandom_range(0, 3);
    for (side = 0; side < 2; side++) begin
      n = (side == 0) ? n_first : n_second;
      r = $urandom;
      case (spread)
        0: cur = r;
        1: cur = longint'(VAL_MIN_W) + $urandom_range(0, 16);
        2: cur = longint'($urandom_range(0, 16)) - 8;
        default: cur = VAL_MAX - $urandom_range(0, 64);
      endcase
      for (k = 0; k < n; k++) begin
        if (ordered) begin
          r   = cur[VAL_W-1:0];
          cur = cur + ((spread == 0) ? $urandom_range(0, 1 << 26) : $urandom_range(0, 3));
          if (cur > VAL_MAX) cur = VAL_MAX;
        end else begin
          r = $urandom;
        end
        if (side == 0) first_run.insert(first_run.size(), r);
        else second_run.insert(second_run.size(), r);
      end
    end
  endtask

  // interleave the staged runs, sprinkle ignored opcodes, then ask for the median
  task automatic send_set(input int noise_pct);
    int i;
    int j;
    i = 0;
    j = 0;
    while (i < first_run.size() || j < second_run.size()) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(OP_IGNORED, $urandom);
      if (j >= second_run.size() || (i < first_run.size() && $urandom_range(0, 1) == 1)) begin
        send_word(med2l_pkg::OP_APPEND_FIRST, first_run[i]);
        i++;
      end else begin
        send_word(med2l_pkg::OP_APPEND_SECOND, second_run[j]);
        j++;
      end
    end
    send_word(med2l_pkg::OP_COMPUTE, $urandom);
  endtask

  // receiver ready: long hold-off when requested, else the current pattern
  always @(negedge clk_i) begin
    rx_phase++;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_RANDOM: m_axis_tready_i <= ($urandom_range(0, 99) < 55);
        RX_CYCLIC: m_axis_tready_i <= (rx_phase % 7) < 4;
        RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 99) < 85);
        default:   m_axis_tready_i <= 1'b1;
      endcase
    end
  end

  // result checker against the oldest queued median
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_flags = med2l_pkg::res_flags_t'(m_axis_tuser_o);
      if (median_expect_q.size() == 0) begin
        $error("unexpected result word: median_doubled %0d", $signed(m_axis_tdata_o[32:0]));
        error_count++;
      end else begin
        exp_res = median_expect_q.pop_front();
        results_checked++;
        if (m_axis_tdata_o[MED_W-1:0] !== exp_res.median) begin
          $error("median_doubled: expected %0d, got %0d", exp_res.median,
                 $signed(m_axis_tdata_o[MED_W-1:0]));
          error_count++;
        end
        if (m_axis_tdata_o[39:MED_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata_o[39:MED_W]);
          error_count++;
        end
        if (got_flags.set_empty !== exp_res.set_empty) begin
          $error("set_empty: expected %0b, got %0b", exp_res.set_empty, got_flags.set_empty);
          error_count++;
        end
        if (got_flags.dropped !== exp_res.dropped) begin
          $error("dropped: expected %0b, got %0b", exp_res.dropped, got_flags.dropped);
          error_count++;
        end
      end
    end
  end

  // empty set, extremes, ties across lists, unsorted input, ignored opcode
  task automatic test_directed();
    gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    send_word(med2l_pkg::OP_COMPUTE, VAL_MAX_W);
    send_word(med2l_pkg::OP_APPEND_FIRST, VAL_MIN_W);
    send_word(med2l_pkg::OP_COMPUTE, 32'sd0);
    send_word(med2l_pkg::OP_APPEND_SECOND, VAL_MAX_W);
    send_word(med2l_pkg::OP_COMPUTE, VAL_MIN_W);
    send_word(med2l_pkg::OP_APPEND_FIRST, VAL_MIN_W);
    send_word(med2l_pkg::OP_APPEND_SECOND, VAL_MAX_W);
    send_word(med2l_pkg::OP_COMPUTE, 32'sd0);
    send_word(med2l_pkg::OP_APPEND_FIRST, 32'sd5);
    send_word(med2l_pkg::OP_APPEND_SECOND, 32'sd5);
    send_word(med2l_pkg::OP_APPEND_FIRST, 32'sd5);
    send_word(OP_IGNORED, -32'sd1);
    send_word(med2l_pkg::OP_APPEND_SECOND, -32'sd3);
    send_word(med2l_pkg::OP_COMPUTE, 32'sd0);
    send_word(OP_IGNORED, 32'h5555_5555);
    send_word(med2l_pkg::OP_APPEND_FIRST, 32'h5555_5555);
    send_word(med2l_pkg::OP_APPEND_SECOND, 32'hAAAA_AAAA);
    send_word(med2l_pkg::OP_APPEND_FIRST, -32'sd1);
    send_word(med2l_pkg::OP_COMPUTE, 32'h1234_5678);
  endtask

  // one list filled past depth, the other short: drop flag and a long merge walk
  task automatic test_list_overflow();
    gaps_on = 1'b0;
    rx_mode = RX_SPARSE;
    if ($urandom_range(0, 1) == 1) begin
      build_runs(LIST_DEPTH + 1, 2, 1'b1);
    end else begin
      build_runs(2, LIST_DEPTH + 1, 1'b1);
    end
    send_set(0);
    // drop flag must be cleared by the previous compute
    send_word(med2l_pkg::OP_COMPUTE, 32'sd0);
  endtask

  // well-formed sets with random content, some unsorted and noisy
  task automatic test_random_sets();
    int start_words;
    int pick;
    int n1;
    int n2;
    start_words = words_sent;
    while (words_sent - start_words < 150) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        n1 = $urandom_range(0, 10);
        n2 = $urandom_range(0, 10);
      end else if (pick < 97) begin
        n1 = $urandom_range(0, 30);
        n2 = $urandom_range(0, 30);
      end else begin
        n1 = $urandom_range(0, 80);
        n2 = $urandom_range(0, 80);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
      build_runs(n1, n2, $urandom_range(0, 9) != 0);
      send_set(($urandom_range(0, 4) == 0) ? 8 : 0);
    end
  endtask

  // receiver holds off while several sets stream in, stalling the input
  task automatic test_backpressure();
    int s;
    gaps_on   = 1'b0;
    rx_mode   = RX_ALWAYS;
    hold_left = 400;
    for (s = 0; s < 4; s++) begin
      build_runs($urandom_range(1, 12), $urandom_range(0, 12), 1'b1);
      send_set(0);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    first_cnt       = 0;
    second_cnt      = 0;
    append_dropped  = 1'b0;
    error_count     = 0;
    results_checked = 0;
    words_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b0;
    rx_mode         = RX_ALWAYS;
    rx_phase        = 0;
    hold_left       = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_list_overflow();
    test_backpressure();
    test_random_sets();
    test_backpressure();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    // drain outstanding medians, then watch for stray words
    rx_mode = RX_RANDOM;
    while (median_expect_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("run covered %0d input words and %0d checked medians", words_sent,
             results_checked);
    $display("incl. empty sets, value extremes, list overflow, unsorted lists, held output");
    if (error_count == 0) begin
      $display("median_of_two_sorted_lists_unit regression: pass");
    end else begin
      $display("median_of_two_sorted_lists_unit regression: fail");
    end
    $finish;
  end

endmodule
